// ===== hdl/tdh_pkg.sv =====
package tdh_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned HidW    = 16;
  localparam int unsigned ArgW    = 32;
  localparam int unsigned PeW     = 16;
  localparam int unsigned PendW   = 7;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_TICK   = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STS_INSERTED = 2'd0,
    STS_FULL     = 2'd1,
    STS_EXPIRED  = 2'd2,
    STS_NONE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0] dl;
    logic [HidW-1:0]  hid;
    logic [ArgW-1:0]  arg;
    logic [PeW-1:0]   pe;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DONE,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_LAST,
    ST_SD_L,
    ST_SD_LW,
    ST_SD_R,
    ST_SD_CMP
  } state_e;

endpackage

// ===== hdl/tdh_if.sv =====
interface tdh_req_if;
  import tdh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [0:0]           action;
  logic [TimeW-1:0]     time_value;
  logic [HidW-1:0]      handler_id;
  logic [ArgW-1:0]      handler_arg;
  logic [PeW-1:0]       target_pe;
  modport source (output valid, action, time_value, handler_id, handler_arg, target_pe,
                  input ready);
  modport sink (input valid, action, time_value, handler_id, handler_arg, target_pe,
                output ready);
endinterface

interface tdh_res_if;
  import tdh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [HidW-1:0]      handler_id_res;
  logic [ArgW-1:0]      handler_arg_out;
  logic [PeW-1:0]       target_pe_out;
  logic [TimeW-1:0]     deadline;
  logic [PendW-1:0]     entries_pending;
  logic                 last;
  modport source (output valid, status, handler_id_res, handler_arg_out, target_pe_out,
                  deadline, entries_pending, last, input ready);
  modport sink (input valid, status, handler_id_res, handler_arg_out, target_pe_out,
                deadline, entries_pending, last, output ready);
endinterface

// ===== hdl/tdh_mem.sv =====
module tdh_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  tdh_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output tdh_pkg::entry_t     rdata_o
);
  import tdh_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/timer_deadline_heap.sv =====
// timer deadline heap: a min-heap of timed callbacks keyed by deadline.
// req_i carries one request: an insert (deadline, handler id, argument,
// target processor) or a tick carrying the current time. res_o returns
// results: one per insert (inserted or refused when full), and for a tick
// one result per entry whose deadline is strictly before the current time,
// earliest first, or a single "none expired" result; last marks the final one.
// The heap sits in a single-port-write, single-port-read memory with
// registered read data; one sequencer walks it, comparing deadlines.
// An insert climbs from the new leaf one level per read and compare until
// its parent is no later or it reaches the root; each pop reads the root,
// moves the last entry there and sifts it down to a leaf or until no child
// is earlier. req_i.ready is low until the request's last
// result has been taken into the output register. Results sit in a single
// output register; when the receiver stalls the sequencer waits on it.
// Reset empties the heap at once (entry count to zero); memory contents are
// not cleared and never read before being written.
module timer_deadline_heap #(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdh_req_if.sink    req_i,
  tdh_res_if.source  res_o
);
  import tdh_pkg::*;

  localparam int unsigned CntW  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned AddrW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     hole_q, hole_d;
  logic [CntW-1:0]     cidx_q, cidx_d;
  entry_t              mov_q, mov_d;
  entry_t              chd_q, chd_d;
  entry_t              hold_q, hold_d;
  logic                hv_q, hv_d;
  logic [TimeW-1:0]    tnow_q, tnow_d;
  status_e             code_q, code_d;

  logic                ov_q, ov_d;
  status_e             ost_q, ost_d;
  entry_t              oent_q, oent_d;
  logic [PendW-1:0]    opend_q, opend_d;
  logic                olast_q, olast_d;

  logic                we, re;
  logic [AddrW-1:0]    waddr, raddr;
  entry_t              wdata, rdata;

  logic                out_free;
  logic                acc;
  logic [CntW:0]       lchild;
  logic [CntW:0]       rchild;
  logic [CntW-1:0]     cnt_dec;

  tdh_mem #(.Depth(HEAP_DEPTH), .AddrW(AddrW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  function automatic logic [AddrW-1:0] slot_addr(input logic [CntW-1:0] slot);
    logic [CntW-1:0] s;
    s = slot - CntW'(1);
    return s[AddrW-1:0];
  endfunction

  assign out_free = !ov_q || res_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign acc = req_i.valid && req_i.ready;
  assign lchild = {hole_q, 1'b0};
  assign rchild = {1'b0, cidx_q} + (CntW+1)'(1);
  assign cnt_dec = cnt_q - CntW'(1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hole_d  = hole_q;
    cidx_d  = cidx_q;
    mov_d   = mov_q;
    chd_d   = chd_q;
    hold_d  = hold_q;
    hv_d    = hv_q;
    tnow_d  = tnow_q;
    code_d  = code_q;
    ov_d    = ov_q && !res_o.ready;
    ost_d   = ost_q;
    oent_d  = oent_q;
    opend_d = opend_q;
    olast_d = olast_q;
    we      = 1'b0;
    waddr   = slot_addr(hole_q);
    wdata   = mov_q;
    re      = 1'b0;
    raddr   = slot_addr(hole_q);

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (action_e'(req_i.action) == ACT_INSERT) begin
            if ({1'b0, cnt_q} >= (CntW+1)'(HEAP_DEPTH)) begin
              code_d  = STS_FULL;
              state_d = ST_DONE;
            end else begin
              cnt_d   = cnt_q + CntW'(1);
              hole_d  = cnt_q + CntW'(1);
              mov_d   = '{dl: req_i.time_value, hid: req_i.handler_id,
                          arg: req_i.handler_arg, pe: req_i.target_pe};
              state_d = ST_INS_RD;
            end
          end else begin
            tnow_d  = req_i.time_value;
            hv_d    = 1'b0;
            state_d = ST_TK_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (hole_q == CntW'(1)) begin
          we      = 1'b1;
          code_d  = STS_INSERTED;
          state_d = ST_DONE;
        end else begin
          re      = 1'b1;
          raddr   = slot_addr(hole_q >> 1);
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (mov_q.dl < rdata.dl) begin
          wdata   = rdata;
          hole_d  = hole_q >> 1;
          state_d = ST_INS_RD;
        end else begin
          code_d  = STS_INSERTED;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = code_q;
          oent_d  = '0;
          opend_d = PendW'(cnt_q);
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_TK_RD: begin
        if (cnt_q == '0) begin
          if (!hv_q) begin
            code_d  = STS_NONE;
            state_d = ST_DONE;
          end else if (out_free) begin
            ov_d    = 1'b1;
            ost_d   = STS_EXPIRED;
            oent_d  = hold_q;
            opend_d = PendW'(cnt_q);
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          re      = 1'b1;
          raddr   = '0;
          state_d = ST_TK_CHK;
        end
      end
      ST_TK_CHK: begin
        if (!(rdata.dl < tnow_q)) begin
          if (!hv_q) begin
            code_d  = STS_NONE;
            state_d = ST_DONE;
          end else if (out_free) begin
            ov_d    = 1'b1;
            ost_d   = STS_EXPIRED;
            oent_d  = hold_q;
            opend_d = PendW'(cnt_q);
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (!hv_q || out_free) begin
          // previous pop goes out now that another one follows it
          if (hv_q) begin
            ov_d    = 1'b1;
            ost_d   = STS_EXPIRED;
            oent_d  = hold_q;
            opend_d = PendW'(cnt_q);
            olast_d = 1'b0;
          end
          hold_d = rdata;
          hv_d   = 1'b1;
          cnt_d  = cnt_dec;
          if (cnt_dec == '0) begin
            state_d = ST_TK_RD;
          end else begin
            re      = 1'b1;
            raddr   = slot_addr(cnt_q);
            state_d = ST_TK_LAST;
          end
        end
      end
      ST_TK_LAST: begin
        mov_d   = rdata;
        hole_d  = CntW'(1);
        state_d = ST_SD_L;
      end
      ST_SD_L: begin
        if (lchild > {1'b0, cnt_q}) begin
          we      = 1'b1;
          state_d = ST_TK_RD;
        end else begin
          re      = 1'b1;
          raddr   = slot_addr(lchild[CntW-1:0]);
          cidx_d  = lchild[CntW-1:0];
          state_d = ST_SD_LW;
        end
      end
      ST_SD_LW: begin
        chd_d = rdata;
        if (rchild <= {1'b0, cnt_q}) begin
          re      = 1'b1;
          raddr   = cidx_q[AddrW-1:0];
          state_d = ST_SD_R;
        end else begin
          state_d = ST_SD_CMP;
        end
      end
      ST_SD_R: begin
        if (chd_q.dl > rdata.dl) begin
          chd_d  = rdata;
          cidx_d = rchild[CntW-1:0];
        end
        state_d = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        we = 1'b1;
        if (mov_q.dl <= chd_q.dl) begin
          state_d = ST_TK_RD;
        end else begin
          wdata   = chd_q;
          hole_d  = cidx_q;
          state_d = ST_SD_L;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      hv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hv_q    <= hv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q  <= hole_d;
    cidx_q  <= cidx_d;
    mov_q   <= mov_d;
    chd_q   <= chd_d;
    hold_q  <= hold_d;
    tnow_q  <= tnow_d;
    code_q  <= code_d;
    ost_q   <= ost_d;
    oent_q  <= oent_d;
    opend_q <= opend_d;
    olast_q <= olast_d;
  end

  assign res_o.valid           = ov_q;
  assign res_o.status          = ost_q;
  assign res_o.handler_id_res  = oent_q.hid;
  assign res_o.handler_arg_out = oent_q.arg;
  assign res_o.target_pe_out   = oent_q.pe;
  assign res_o.deadline        = oent_q.dl;
  assign res_o.entries_pending = opend_q;
  assign res_o.last            = olast_q;

endmodule

// ===== tb/timer_deadline_heap_test.sv =====
`timescale 1ns / 1ps

module timer_deadline_heap_test;
  import tdh_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned LimitCycles = 400000;

  typedef struct packed {
    logic [1:0]       status;
    logic [HidW-1:0]  hid;
    logic [ArgW-1:0]  arg;
    logic [PeW-1:0]   pe;
    logic [TimeW-1:0] dl;
    logic [PendW-1:0] pending;
    logic             last;
  } result_t;

  // timer queue mirror: predicts the results of each request
  class timer_queue_board;
    entry_t    slots[Depth+1];
    int unsigned count;
    result_t   awaited[$];
    int unsigned errors;

    function void swap_entries(int unsigned a, int unsigned b);
      entry_t t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void note_request(action_e act, logic [TimeW-1:0] tv, logic [HidW-1:0] hid,
                               logic [ArgW-1:0] arg, logic [PeW-1:0] pe);
      result_t r;
      int unsigned c, p, was, n;
      r = '0;
      n = 0;
      if (act == ACT_INSERT) begin
        if (count >= Depth) begin
          r.status = STS_FULL;
        end else begin
          count++;
          c = count;
          slots[c] = '{dl: tv, hid: hid, arg: arg, pe: pe};
          p = c / 2;
          while (p > 0 && slots[c].dl < slots[p].dl) begin
            swap_entries(c, p);
            c = p;
            p = p / 2;
          end
          r.status = STS_INSERTED;
        end
        r.pending = PendW'(count);
        r.last = 1'b1;
        awaited.push_back(r);
        return;
      end
      while (count > 0 && slots[1].dl < tv) begin
        was = count;
        swap_entries(1, count);
        count--;
        p = 1;
        c = 2;
        while (c <= count) begin
          if (c + 1 <= count && slots[c].dl > slots[c+1].dl) c++;
          if (slots[p].dl <= slots[c].dl) break;
          swap_entries(p, c);
          p = c;
          c = 2 * c;
        end
        r = '0;
        r.status = STS_EXPIRED;
        r.hid = slots[was].hid;
        r.arg = slots[was].arg;
        r.pe = slots[was].pe;
        r.dl = slots[was].dl;
        r.pending = PendW'(count);
        awaited.push_back(r);
        n++;
      end
      if (n == 0) begin
        r = '0;
        r.status = STS_NONE;
        r.pending = PendW'(count);
        awaited.push_back(r);
      end
      awaited[$].last = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status) $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
      if (got.hid !== e.hid) $display("%0t: handler exp %h got %h", $time, e.hid, got.hid);
      if (got.arg !== e.arg) $display("%0t: arg exp %h got %h", $time, e.arg, got.arg);
      if (got.pe !== e.pe) $display("%0t: pe exp %h got %h", $time, e.pe, got.pe);
      if (got.dl !== e.dl) $display("%0t: deadline exp %h got %h", $time, e.dl, got.dl);
      if (got.pending !== e.pending)
        $display("%0t: pending exp %0d got %0d", $time, e.pending, got.pending);
      if (got.last !== e.last) $display("%0t: last exp %0d got %0d", $time, e.last, got.last);
      if (got !== e) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  tdh_req_if req_if();
  tdh_res_if res_if();
  timer_deadline_heap #(.HEAP_DEPTH(Depth)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .res_o(res_if.source));

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  timer_queue_board board = new();
  int unsigned cycle_count = 0;
  int unsigned req_idle_pct = 19;
  int unsigned res_idle_pct = 19;
  bit          res_hold = 1'b0;
  logic [TimeW-1:0] now_ticks = '0;

  initial begin
    req_if.valid = 1'b0;
    req_if.action = ACT_INSERT;
    req_if.time_value = '0;
    req_if.handler_id = '0;
    req_if.handler_arg = '0;
    req_if.target_pe = '0;
    res_if.ready = 1'b0;
  end

  // request accepted: update the mirror; result taken: check it
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      board.note_request(action_e'(req_if.action), req_if.time_value, req_if.handler_id,
                         req_if.handler_arg, req_if.target_pe);
    if (rst_ni && res_if.valid && res_if.ready)
      board.check_result({res_if.status, res_if.handler_id_res, res_if.handler_arg_out,
                          res_if.target_pe_out, res_if.deadline, res_if.entries_pending,
                          res_if.last});
  end

  // receiver side, with its own long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else res_if.ready <= !res_hold && ($urandom_range(99) >= res_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(action_e act, logic [TimeW-1:0] tv, logic [HidW-1:0] hid,
                      logic [ArgW-1:0] arg, logic [PeW-1:0] pe);
    while ($urandom_range(99) < req_idle_pct) @(posedge clk_i);
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.time_value <= tv;
    req_if.handler_id <= hid;
    req_if.handler_arg <= arg;
    req_if.target_pe <= pe;
    do @(posedge clk_i); while (!req_if.ready);
    req_if.valid <= 1'b0;
    // the block is busy for the next cycle anyway
    @(posedge clk_i);
  endtask

  task automatic send_insert(logic [TimeW-1:0] dl);
    send(ACT_INSERT, dl, HidW'($urandom), ArgW'($urandom), PeW'($urandom));
  endtask

  task automatic send_tick(logic [TimeW-1:0] tv);
    send(ACT_TICK, tv, HidW'($urandom), ArgW'($urandom), PeW'($urandom));
  endtask

  task automatic drain();
    while (board.awaited.size() != 0) @(posedge clk_i);
  endtask

  // deadlines near the running clock, with many repeats
  function automatic logic [TimeW-1:0] near_time();
    return now_ticks + TimeW'($urandom_range(40));
  endfunction

  initial begin
    int unsigned k;
    logic [TimeW-1:0] big;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, extremes, equal deadlines
    send_tick('1);
    send(ACT_INSERT, '1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send(ACT_INSERT, '0, 16'h0000, 32'h0000_0000, 16'h0000);
    send_insert(48'd100);
    send_insert(48'd100);
    send_tick(48'd0);
    send_tick(48'd1);
    send_tick(48'd100);
    send_tick(48'd101);
    send_tick('1);
    big = '1;
    send_tick(big - 1);
    drain();

    // fill to full while the receiver holds off, then overflow
    res_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        res_hold = 1'b0;
      end
      for (k = 0; k < Depth + 2; k++) send_insert(TimeW'($urandom_range(1000)));
    join
    send_insert(48'd5);
    send_tick(48'd2000);
    drain();
    repeat (40) @(posedge clk_i);

    // random traffic, no idling for the first stretch
    req_idle_pct = 0;
    res_idle_pct = 0;
    for (k = 0; k < 250; k++) begin
      if (k == 60) begin
        req_idle_pct = 19;
        res_idle_pct = 19;
      end
      if (k == 150) drain();
      case ($urandom_range(9))
        0: send_tick(TimeW'({$urandom, $urandom}));
        1: send_insert(TimeW'({$urandom, $urandom}));
        2, 3: begin
          now_ticks = now_ticks + TimeW'($urandom_range(30));
          send_tick(now_ticks);
        end
        default: send_insert(near_time());
      endcase
    end
    send_tick('1);
    drain();
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
